/* design/toy_cpu_instruction_executor_macros.svh */
// Assertion macros used by the checker file.
`ifndef TOY_CPU_INSTRUCTION_EXECUTOR_MACROS_SVH
`define TOY_CPU_INSTRUCTION_EXECUTOR_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define TCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("tce check failed: same-cycle implication");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define TCE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("tce check failed: next-cycle implication");

`endif

/* design/tce_pkg.sv */
package tce_pkg;

  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = $clog2(NUM_REGS);

  typedef logic [REG_IDX_W-1:0] ridx_t;

  typedef enum logic [7:0] {
    OP_NOP     = 8'h00,
    OP_MOV_RR  = 8'h01,
    OP_MOV_IMM = 8'h02,
    OP_LOAD    = 8'h03,
    OP_STORE   = 8'h04,
    OP_ADD     = 8'h10,
    OP_SUB     = 8'h11,
    OP_INC     = 8'h12,
    OP_DEC     = 8'h13,
    OP_AND     = 8'h20,
    OP_OR      = 8'h21,
    OP_XOR     = 8'h22,
    OP_NOT     = 8'h23,
    OP_JMP     = 8'h40,
    OP_JZ      = 8'h41,
    OP_JNZ     = 8'h42,
    OP_CALL    = 8'h43,
    OP_RET     = 8'h44,
    OP_IN      = 8'h60,
    OP_OUT     = 8'h61,
    OP_HALT    = 8'hFF
  } op_e;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_BAD_REG = 2'd1,
    ERR_BAD_OP  = 2'd2
  } err_e;

  // Fixed registers used by the short-form ALU ops.
  localparam ridx_t R0 = ridx_t'(0);
  localparam ridx_t R1 = ridx_t'(1);
  localparam ridx_t R2 = ridx_t'(2);

  typedef struct packed {
    logic       wr_en;
    logic [3:0] wr_nib;
    logic [7:0] wr_val;
    logic [7:0] pc;
    logic       zero;
    logic       halt;
    err_e       err;
  } res_t;

endpackage

/* design/toy_cpu_instruction_executor.sv */
// Toy 8-bit instruction executor.
// Input channel s_axis: one instruction word per handshake (opcode and two
// operand bytes). Output channel m_axis: one result word per instruction,
// in order: register write, program counter, zero and halt flags, error code.
// An accepted instruction loads the execute stage; its result is registered in
// the output register when the execute stage fires and is on m_axis from then on.
// Throughput: one instruction per cycle while m_axis is not stalled. The register
// file is a two-read, one-write memory with a registered read; operands are read at
// acceptance and a write from the instruction ahead is forwarded, so dependent
// instructions still issue back to back.
// Reset clears the register file (per-entry valid bits), program counter,
// return register and both flags at once; no clearing pass is needed.
// When m_axis_tready is low the result word holds in the output register,
// the execute stage holds behind it, and s_axis_tready drops while the execute
// stage is occupied, until the output register drains.
module toy_cpu_instruction_executor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] op, [15:8] first_operand, [23:16] second_operand
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] write_enable, [3:1] write_index, [11:4] write_value,
  // [19:12] program_counter, [20] zero, [21] halt_flag, [23:22] error_code
  output logic [23:0] m_axis_tdata
);

  logic          s_acc;
  logic          ex_fire;
  logic          ex_valid_q;
  logic [7:0]    ex_op_q, ex_a_q, ex_b_q;
  logic [7:0]    op_in, a_in;
  tce_pkg::ridx_t rd_addr_a, rd_addr_b;
  logic [7:0]    rd_a, rd_b;
  logic [7:0]    opnd_a, opnd_b;
  logic          fwd_a_q, fwd_b_q;
  logic [7:0]    fwd_val_q;
  tce_pkg::res_t res;
  tce_pkg::ridx_t wr_addr;
  logic          out_valid_q;
  logic [23:0]   out_data_q;

  assign op_in = s_axis_tdata[7:0];
  assign a_in  = s_axis_tdata[15:8];

  assign ex_fire       = ex_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !ex_valid_q || ex_fire;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // Port A: mov/add source-or-destination nibble, else r1. Port B: add source, else r2.
  always_comb begin
    rd_addr_a = tce_pkg::R1;
    rd_addr_b = tce_pkg::R2;
    if (op_in == tce_pkg::OP_MOV_RR || op_in == tce_pkg::OP_ADD) begin
      rd_addr_a = a_in[tce_pkg::REG_IDX_W+3:4];
    end
    if (op_in == tce_pkg::OP_ADD) begin
      rd_addr_b = a_in[tce_pkg::REG_IDX_W-1:0];
    end
  end

  assign wr_addr = res.wr_nib[tce_pkg::REG_IDX_W-1:0];

  tce_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (ex_fire && res.wr_en),
    .waddr_i   (wr_addr),
    .wdata_i   (res.wr_val),
    .re_i      (s_acc),
    .raddr_a_i (rd_addr_a),
    .raddr_b_i (rd_addr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // A read in the same cycle as the write ahead of it sees the old entry: forward.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_a_q <= 1'b0;
      fwd_b_q <= 1'b0;
    end else if (s_acc) begin
      fwd_a_q <= ex_fire && res.wr_en && (wr_addr == rd_addr_a);
      fwd_b_q <= ex_fire && res.wr_en && (wr_addr == rd_addr_b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      fwd_val_q <= res.wr_val;
      ex_op_q   <= op_in;
      ex_a_q    <= a_in;
      ex_b_q    <= s_axis_tdata[23:16];
    end
  end

  assign opnd_a = fwd_a_q ? fwd_val_q : rd_a;
  assign opnd_b = fwd_b_q ? fwd_val_q : rd_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q <= 1'b0;
    end else if (s_acc) begin
      ex_valid_q <= 1'b1;
    end else if (ex_fire) begin
      ex_valid_q <= 1'b0;
    end
  end

  tce_exec u_exec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (ex_fire),
    .op_i   (ex_op_q),
    .a_i    (ex_a_q),
    .b_i    (ex_b_q),
    .ra_i   (opnd_a),
    .rb_i   (opnd_b),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ex_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_fire) begin
      out_data_q <= {res.err, res.halt, res.zero, res.pc, res.wr_val,
                     res.wr_nib[2:0], res.wr_en};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* design/tce_regfile.sv */
module tce_regfile (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               we_i,
  input  tce_pkg::ridx_t     waddr_i,
  input  logic [7:0]         wdata_i,
  input  logic               re_i,
  input  tce_pkg::ridx_t     raddr_a_i,
  input  tce_pkg::ridx_t     raddr_b_i,
  output logic [7:0]         rdata_a_o,
  output logic [7:0]         rdata_b_o
);

  logic [7:0]                  mem [tce_pkg::NUM_REGS];
  logic [tce_pkg::NUM_REGS-1:0] vld_q;
  logic [7:0]                  rdata_a_q;
  logic [7:0]                  rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= vld_q[raddr_a_i] ? mem[raddr_a_i] : 8'd0;
      rdata_b_q <= vld_q[raddr_b_i] ? mem[raddr_b_i] : 8'd0;
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

/* design/tce_exec.sv */
module tce_exec (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  logic [7:0]    op_i,
  input  logic [7:0]    a_i,
  input  logic [7:0]    b_i,
  input  logic [7:0]    ra_i,
  input  logic [7:0]    rb_i,
  output tce_pkg::res_t res_o
);

  logic [7:0] pc_q, pc_d;
  logic [7:0] ret_q, ret_d;
  logic       zero_q, zero_d;
  logic       halt_q, halt_d;
  logic [3:0] hi, lo;
  logic       hi_ok, lo_ok;
  logic       alu_wr;
  logic [7:0] alu_val;
  tce_pkg::res_t res;

  assign hi    = a_i[7:4];
  assign lo    = a_i[3:0];
  assign hi_ok = {1'b0, hi} < 5'(tce_pkg::NUM_REGS);
  assign lo_ok = {1'b0, lo} < 5'(tce_pkg::NUM_REGS);

  always_comb begin
    pc_d        = pc_q;
    ret_d       = ret_q;
    zero_d      = zero_q;
    halt_d      = halt_q;
    alu_wr      = 1'b0;
    alu_val     = 8'd0;
    res.wr_en   = 1'b0;
    res.wr_nib  = 4'd0;
    res.wr_val  = 8'd0;
    res.err     = tce_pkg::ERR_OK;
    case (op_i)
      tce_pkg::OP_NOP, tce_pkg::OP_LOAD, tce_pkg::OP_STORE,
      tce_pkg::OP_IN, tce_pkg::OP_OUT: begin
      end
      tce_pkg::OP_MOV_RR: begin
        if (hi_ok && lo_ok) begin
          res.wr_en  = 1'b1;
          res.wr_nib = lo;
          res.wr_val = ra_i;
        end else begin
          res.err = tce_pkg::ERR_BAD_REG;
        end
      end
      tce_pkg::OP_MOV_IMM: begin
        if (lo_ok) begin
          res.wr_en  = 1'b1;
          res.wr_nib = lo;
          res.wr_val = b_i;
        end else begin
          res.err = tce_pkg::ERR_BAD_REG;
        end
      end
      tce_pkg::OP_ADD: begin
        if (hi_ok && lo_ok) begin
          alu_wr     = 1'b1;
          alu_val    = ra_i + rb_i;
          res.wr_nib = hi;
        end else begin
          res.err = tce_pkg::ERR_BAD_REG;
        end
      end
      tce_pkg::OP_SUB: begin
        alu_wr  = 1'b1;
        alu_val = ra_i - rb_i;
      end
      tce_pkg::OP_INC: begin
        alu_wr     = 1'b1;
        alu_val    = ra_i + 8'd1;
        res.wr_nib = 4'(tce_pkg::R1);
      end
      tce_pkg::OP_DEC: begin
        alu_wr     = 1'b1;
        alu_val    = ra_i - 8'd1;
        res.wr_nib = 4'(tce_pkg::R1);
      end
      tce_pkg::OP_AND: begin
        alu_wr  = 1'b1;
        alu_val = ra_i & rb_i;
      end
      tce_pkg::OP_OR: begin
        alu_wr  = 1'b1;
        alu_val = ra_i | rb_i;
      end
      tce_pkg::OP_XOR: begin
        alu_wr  = 1'b1;
        alu_val = ra_i ^ rb_i;
      end
      tce_pkg::OP_NOT: begin
        alu_wr  = 1'b1;
        alu_val = ~ra_i;
      end
      tce_pkg::OP_JMP: pc_d = a_i;
      tce_pkg::OP_JZ: begin
        if (zero_q) pc_d = a_i;
      end
      tce_pkg::OP_JNZ: begin
        if (!zero_q) pc_d = a_i;
      end
      tce_pkg::OP_CALL: begin
        ret_d = pc_q;
        pc_d  = a_i;
      end
      tce_pkg::OP_RET:  pc_d   = ret_q;
      tce_pkg::OP_HALT: halt_d = 1'b1;
      default: res.err = tce_pkg::ERR_BAD_OP;
    endcase
    // ALU results also set the zero flag; destination defaults to r0.
    if (alu_wr) begin
      res.wr_en  = 1'b1;
      res.wr_val = alu_val;
      zero_d     = (alu_val == 8'd0);
    end
    res.pc   = pc_d;
    res.zero = zero_d;
    res.halt = halt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= 8'd0;
      ret_q  <= 8'd0;
      zero_q <= 1'b0;
      halt_q <= 1'b0;
    end else if (fire_i) begin
      pc_q   <= pc_d;
      ret_q  <= ret_d;
      zero_q <= zero_d;
      halt_q <= halt_d;
    end
  end

  assign res_o = res;

endmodule

/* design/tce_checker.sv */
`include "toy_cpu_instruction_executor_macros.svh"

module tce_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  `TCE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `TCE_ASSERT_NXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  // A word without a register write carries zero index and value.
  `TCE_ASSERT_IMP(a_no_wr_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[11:1] == 11'd0)
  // A failed instruction writes nothing, and no error code above two appears.
  `TCE_ASSERT_IMP(a_err_no_wr, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata[23:22] != tce_pkg::ERR_OK), !m_axis_tdata[0] && (m_axis_tdata[23:22] == tce_pkg::ERR_BAD_REG || m_axis_tdata[23:22] == tce_pkg::ERR_BAD_OP))

endmodule

bind toy_cpu_instruction_executor tce_checker u_tce_checker (.*);

/* dv/toy_cpu_instruction_executor_tb.sv */
module toy_cpu_instruction_executor_tb;
  import tce_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct {
    logic       wen;
    logic [2:0] widx;
    logic [7:0] wval;
    logic [7:0] pc;
    logic       zf;
    logic       halt;
    err_e       err;
  } exec_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [7:0] op, [15:8] first_operand, [23:16] second_operand
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [0] write_enable, [3:1] write_index, [11:4] write_value,
  // [19:12] program_counter, [20] zero, [21] halt_flag, [23:22] error_code
  logic [23:0] m_axis_tdata;

  // Shadow machine state
  logic [7:0] shadow_regs [NUM_REGS];
  logic [7:0] shadow_pc;
  logic [7:0] shadow_ret;
  logic       shadow_zf;
  logic       shadow_halt;

  exec_result_t pending_results [$];
  int unsigned  instr_count;
  int unsigned  result_count;
  int unsigned  fail_count;
  int unsigned  idle_cycles;
  bit           no_idle;

  op_e op_list [21] = '{OP_NOP, OP_MOV_RR, OP_MOV_IMM, OP_LOAD, OP_STORE, OP_ADD, OP_SUB,
                        OP_INC, OP_DEC, OP_AND, OP_OR, OP_XOR, OP_NOT, OP_JMP, OP_JZ,
                        OP_JNZ, OP_CALL, OP_RET, OP_IN, OP_OUT, OP_HALT};

  toy_cpu_instruction_executor i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Execute one instruction on the shadow machine and return its result word.
  task automatic execute_instr(input logic [7:0] op, input logic [7:0] a,
                               input logic [7:0] b, output exec_result_t r);
    logic [3:0] hi;
    logic [3:0] lo;
    logic       alu;
    logic [3:0] widx;
    logic [7:0] wval;
    hi    = a[7:4];
    lo    = a[3:0];
    alu   = 1'b0;
    widx  = '0;
    wval  = '0;
    r.wen = 1'b0;
    r.err = ERR_OK;
    case (op)
      OP_NOP, OP_LOAD, OP_STORE, OP_IN, OP_OUT: ;
      OP_MOV_RR: begin
        if (hi < NUM_REGS && lo < NUM_REGS) begin
          r.wen = 1'b1;
          widx  = lo;
          wval  = shadow_regs[hi[2:0]];
        end else begin
          r.err = ERR_BAD_REG;
        end
      end
      OP_MOV_IMM: begin
        if (lo < NUM_REGS) begin
          r.wen = 1'b1;
          widx  = lo;
          wval  = b;
        end else begin
          r.err = ERR_BAD_REG;
        end
      end
      OP_ADD: begin
        // destination sits in the high nibble here, unlike mov
        if (hi < NUM_REGS && lo < NUM_REGS) begin
          r.wen = 1'b1;
          alu   = 1'b1;
          widx  = hi;
          wval  = shadow_regs[hi[2:0]] + shadow_regs[lo[2:0]];
        end else begin
          r.err = ERR_BAD_REG;
        end
      end
      OP_SUB, OP_AND, OP_OR, OP_XOR, OP_NOT: begin
        r.wen = 1'b1;
        alu   = 1'b1;
        widx  = 4'(R0);
        case (op)
          OP_SUB:  wval = shadow_regs[R1] - shadow_regs[R2];
          OP_AND:  wval = shadow_regs[R1] & shadow_regs[R2];
          OP_OR:   wval = shadow_regs[R1] | shadow_regs[R2];
          OP_XOR:  wval = shadow_regs[R1] ^ shadow_regs[R2];
          default: wval = ~shadow_regs[R1];
        endcase
      end
      OP_INC, OP_DEC: begin
        r.wen = 1'b1;
        alu   = 1'b1;
        widx  = 4'(R1);
        wval  = (op == OP_INC) ? shadow_regs[R1] + 8'd1 : shadow_regs[R1] - 8'd1;
      end
      OP_JMP: shadow_pc = a;
      OP_JZ:  if (shadow_zf) shadow_pc = a;
      OP_JNZ: if (!shadow_zf) shadow_pc = a;
      OP_CALL: begin
        shadow_ret = shadow_pc;
        shadow_pc  = a;
      end
      OP_RET:  shadow_pc = shadow_ret;
      OP_HALT: shadow_halt = 1'b1;
      default: r.err = ERR_BAD_OP;
    endcase
    if (r.wen) shadow_regs[widx[2:0]] = wval;
    if (alu) shadow_zf = (wval == 8'd0);
    r.widx = widx[2:0];
    r.wval = wval;
    r.pc   = shadow_pc;
    r.zf   = shadow_zf;
    r.halt = shadow_halt;
  endtask

  task automatic send_instr(input logic [7:0] op, input logic [7:0] a, input logic [7:0] b);
    int unsigned  gap;
    exec_result_t r;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a, op};
    do @(posedge clk_i); while (!s_axis_tready);
    execute_instr(op, a, b, r);
    pending_results = {pending_results, r};
    instr_count++;
  endtask

  function automatic void check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, want, got);
      fail_count++;
    end
  endfunction

  task automatic test_directed();
    send_instr(OP_MOV_IMM, 8'h01, 8'hFF);  // r1 = FF
    send_instr(OP_MOV_IMM, 8'hF2, 8'h00);  // high nibble ignored, r2 = 0
    send_instr(OP_MOV_IMM, 8'h08, 8'h55);  // bad destination
    send_instr(OP_MOV_RR,  8'h13, 8'h00);  // r3 = r1
    send_instr(OP_MOV_RR,  8'h90, 8'h00);  // bad source
    send_instr(OP_MOV_RR,  8'h0F, 8'h00);  // bad destination
    send_instr(OP_ADD,     8'h31, 8'h00);  // r3 = FF + FF wraps
    send_instr(OP_ADD,     8'h8F, 8'h00);  // both nibbles bad
    send_instr(OP_SUB,     8'h00, 8'h00);
    send_instr(OP_INC,     8'h00, 8'h00);  // FF -> 00, zero set
    send_instr(OP_JZ,      8'hFF, 8'h00);  // taken
    send_instr(OP_DEC,     8'h00, 8'h00);  // 00 -> FF
    send_instr(OP_JNZ,     8'h00, 8'h00);  // taken
    send_instr(OP_AND,     8'h00, 8'h00);  // zero again
    send_instr(OP_JNZ,     8'h80, 8'h00);  // not taken
    send_instr(OP_JZ,      8'h7F, 8'h00);
    send_instr(OP_OR,      8'h00, 8'h00);
    send_instr(OP_XOR,     8'h00, 8'h00);
    send_instr(OP_NOT,     8'h00, 8'h00);
    send_instr(OP_CALL,    8'hAA, 8'h00);
    send_instr(OP_CALL,    8'h55, 8'h00);  // overwrites return address
    send_instr(OP_RET,     8'h00, 8'h00);
    send_instr(OP_JMP,     8'h00, 8'hFF);
    send_instr(OP_LOAD,    8'h12, 8'h34);
    send_instr(OP_STORE,   8'h21, 8'h43);
    send_instr(OP_IN,      8'hFF, 8'hFF);
    send_instr(OP_OUT,     8'h00, 8'h00);
    send_instr(8'h05,      8'h11, 8'h22);  // unknown opcode
    send_instr(8'hFE,      8'h00, 8'h00);  // unknown opcode
  endtask

  task automatic send_random(input int unsigned count);
    logic [7:0] op;
    logic [7:0] a;
    logic [7:0] b;
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) op = 8'($urandom);
      else op = op_list[$urandom_range(0, 20)];
      a = 8'($urandom);
      b = 8'($urandom);
      // keep most register nibbles in range so moves and adds mostly execute
      if ((op == OP_MOV_RR || op == OP_MOV_IMM || op == OP_ADD) && $urandom_range(0, 4) != 0)
        a = {1'b0, a[6:4], 1'b0, a[2:0]};
      // halt is sticky, so keep it rare
      if (op == OP_HALT && $urandom_range(0, 3) != 0) op = OP_NOP;
      send_instr(op, a, b);
    end
  endtask

  task automatic test_random_back_to_back();
    no_idle = 1'b1;
    send_random(150);
    no_idle = 1'b0;
  endtask

  task automatic test_drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    send_instr(OP_NOT, 8'h00, 8'h00);
  endtask

  task automatic test_random_stalls();
    send_random(570);
  endtask

  // Result side: random stalls, then compare each word with the oldest prediction
  initial begin
    exec_result_t want;
    int unsigned  stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      result_count++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual 0x%06h",
                 $time, m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("write_enable",    want.wen,  m_axis_tdata[0]);
        check_field("write_index",     want.widx, m_axis_tdata[3:1]);
        check_field("write_value",     want.wval, m_axis_tdata[11:4]);
        check_field("program_counter", want.pc,   m_axis_tdata[19:12]);
        check_field("zero",            want.zf,   m_axis_tdata[20]);
        check_field("halt_flag",       want.halt, m_axis_tdata[21]);
        check_field("error_code",      want.err,  m_axis_tdata[23:22]);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("[toy_cpu_instruction_executor] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    for (int i = 0; i < NUM_REGS; i++) shadow_regs[i] = '0;
    shadow_pc    = '0;
    shadow_ret   = '0;
    shadow_zf    = 1'b0;
    shadow_halt  = 1'b0;
    instr_count  = 0;
    result_count = 0;
    fail_count   = 0;
    idle_cycles  = 0;
    no_idle      = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_back_to_back();
    test_drain();
    test_random_stalls();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      fail_count++;
    end
    $display("Executed %0d instructions (all opcodes, bad register and opcode cases,",
             instr_count);
    $display("back-to-back and stalled traffic); %0d results, %0d mismatches",
             result_count, fail_count);
    if (fail_count == 0) begin
      $display("[toy_cpu_instruction_executor] OK");
    end else begin
      $display("[toy_cpu_instruction_executor] ERROR");
    end
    $finish;
  end

endmodule

/* toy_cpu_instruction_executor.f */
+incdir+design
design/tce_pkg.sv
design/tce_regfile.sv
design/tce_exec.sv
design/toy_cpu_instruction_executor.sv
design/tce_checker.sv
dv/toy_cpu_instruction_executor_tb.sv
